@@ rtl/core/bpq_pkg.sv @@
`timescale 1ns / 1ps
package bpq_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 6;
    localparam int OCC_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        F_ENQ    = 3'd0,
        F_DEQ    = 3'd1,
        F_FIND   = 3'd2,
        F_REMID  = 3'd3,
        F_FIRST  = 3'd4,
        F_NEXT   = 3'd5,
        F_REMCUR = 3'd6,
        F_CLEAR  = 3'd7
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   element_id;
        logic [PRIO_W-1:0] priority_req;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]  element_out;
        logic             valid_res;
        logic             flushed;
        logic             ok;
        logic [POS_W-1:0] position;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } t_res;
endpackage

@@ rtl/core/bpq_if.sv @@
`timescale 1ns / 1ps
interface bpq_cmd_if import bpq_pkg::*; ();
    logic valid;
    logic ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   element_id;
    logic [PRIO_W-1:0] priority_req;
    modport source (output valid, func, element_id, priority_req, input ready);
    modport sink   (input valid, func, element_id, priority_req, output ready);
endinterface

interface bpq_res_if import bpq_pkg::*; ();
    logic valid;
    logic ready;
    logic [ID_W-1:0]  element_out;
    logic             valid_res;
    logic             flushed;
    logic             ok;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
    logic             last;
    modport source (output valid, element_out, valid_res, flushed, ok, position,
                    occupancy, last, input ready);
    modport sink   (input valid, element_out, valid_res, flushed, ok, position,
                    occupancy, last, output ready);
endinterface

@@ rtl/core/bounded_priority_queue.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake     Payload
// s_cmd    in   valid/ready   func, element_id, priority_req
// m_res    out  valid/ready   element_out, valid_res, flushed, ok, position,
//                             occupancy, last
// In the sorted array an item is loaded, then gives one result from the array
// sequencer; a flush first emits one flushed result per entry held.
// i_rst_n is synchronous: it empties the queue and the cursor.
// A two-entry command queue takes items while the array works; a held
// result stalls the array, and the input once that queue has filled.
module bounded_priority_queue import bpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bpq_cmd_if.sink   s_cmd,
    bpq_res_if.source m_res
);
    logic w_cmd_valid, w_take;
    t_cmd w_cmd;

    bpq_front u_front (
        .i_clk, .i_rst_n, .s_cmd,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );

    bpq_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_take),
        .m_res
    );
endmodule

@@ rtl/core/bpq_front.sv @@
`timescale 1ns / 1ps
// Two-entry command queue between the input channel and the sorted array.
module bpq_front import bpq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bpq_cmd_if.sink s_cmd,
    output logic   o_cmd_valid,
    output t_cmd   o_cmd,
    input  logic   i_cmd_take
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign s_cmd.ready = (r_cnt != 2'd2);
    assign w_push      = s_cmd.valid && s_cmd.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];

    // store payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{func: s_cmd.func, element_id: s_cmd.element_id,
                             priority_req: s_cmd.priority_req};
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_take};
        end
    end

    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> o_cmd_valid) else $error("take from empty queue");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push) else $error("push into full queue");
endmodule

@@ rtl/core/bpq_back.sv @@
`timescale 1ns / 1ps
// Sorted register array: compares all entries in parallel, shifts them together.
module bpq_back import bpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_take,
    bpq_res_if.source m_res
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_OUT} t_state;

    t_state              r_state;
    logic [ID_W-1:0]     r_ids  [CAPACITY];
    logic [PRIO_W-1:0]   r_prio [CAPACITY];
    logic [CW-1:0]       r_cnt;
    logic [IW-1:0]       r_cur;
    logic                r_cur_v;
    logic [CW-1:0]       r_fidx;
    t_cmd                r_cmd;
    t_res                r_res;
    logic                r_res_v;

    logic [CAPACITY-1:0] w_ge, w_match;
    logic [CW-1:0]       w_ins, w_fpos;
    logic                w_found;
    logic                w_out_free;

    assign w_out_free = !r_res_v || m_res.ready;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    // parallel compares against the incoming command
    always_comb begin
        w_ins   = '0;
        w_fpos  = '0;
        w_found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_ge[i]    = (CW'(i) < r_cnt) && (r_prio[i] >= r_cmd.priority_req);
            w_match[i] = (CW'(i) < r_cnt) && (r_ids[i] == r_cmd.element_id);
        end
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found = 1'b1;
                w_fpos  = CW'(i);
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_ge[i]) w_ins = CW'(i + 1);
        end
    end

    // sequencer, array update and registered result
    always_ff @(posedge i_clk) begin
        logic [CW-1:0] v_rm;
        logic          v_do_rm;
        logic [CW-1:0] v_cnt;
        t_res          v_res;
        logic          v_res_v;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cur   <= '0;
            r_cur_v <= 1'b0;
            r_res_v <= 1'b0;
            r_fidx  <= '0;
        end else begin
            v_res   = r_res;
            v_res_v = r_res_v;
            if (m_res.valid && m_res.ready) v_res_v = 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_fidx <= '0;
                        if ((i_cmd.func == F_CLEAR && r_cnt != '0) ||
                            (i_cmd.func == F_ENQ && r_cnt == CW'(CAPACITY)))
                            r_state <= S_FLUSH;
                        else
                            r_state <= S_OUT;
                    end
                end
                S_FLUSH: begin
                    // emit one flushed entry per transfer
                    if (w_out_free) begin
                        v_res_v = 1'b1;
                        v_res   = '{element_out: r_ids[r_fidx[IW-1:0]],
                                    valid_res: 1'b1, flushed: 1'b1, ok: 1'b0,
                                    position: POS_W'(r_fidx),
                                    occupancy: (r_cmd.func == F_CLEAR) ?
                                               OCC_W'(0) : OCC_W'(1),
                                    last: 1'b0};
                        if (r_fidx == r_cnt - CW'(1)) begin
                            r_cnt   <= '0;
                            r_cur_v <= 1'b0;
                            r_cur   <= '0;
                            r_state <= S_OUT;
                        end
                        r_fidx <= r_fidx + CW'(1);
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        v_res_v = 1'b1;
                        r_state <= S_IDLE;
                        v_res   = '{element_out: '0, valid_res: 1'b0,
                                    flushed: 1'b0, ok: 1'b0, position: '0,
                                    occupancy: OCC_W'(r_cnt), last: 1'b1};
                        v_do_rm = 1'b0;
                        v_rm    = '0;
                        v_cnt   = r_cnt;
                        case (r_cmd.func)
                            F_ENQ: begin
                                for (int i = CAPACITY - 1; i > 0; i--) begin
                                    if (CW'(i) > w_ins) begin
                                        r_ids[i]  <= r_ids[i-1];
                                        r_prio[i] <= r_prio[i-1];
                                    end
                                end
                                r_ids[w_ins[IW-1:0]]  <= r_cmd.element_id;
                                r_prio[w_ins[IW-1:0]] <= r_cmd.priority_req;
                                r_cnt <= r_cnt + CW'(1);
                                if (r_cur_v && CW'(r_cur) >= w_ins)
                                    r_cur <= r_cur + IW'(1);
                                v_res = '{element_out: r_cmd.element_id,
                                          valid_res: 1'b1, flushed: 1'b0,
                                          ok: 1'b1, position: POS_W'(w_ins),
                                          occupancy: OCC_W'(r_cnt + CW'(1)),
                                          last: 1'b1};
                            end
                            F_DEQ: begin
                                if (r_cnt != '0) begin
                                    v_cnt = r_cnt - CW'(1);
                                    v_res = '{element_out: r_ids[0],
                                              valid_res: 1'b1, flushed: 1'b0,
                                              ok: 1'b1, position: '0,
                                              occupancy: OCC_W'(v_cnt),
                                              last: 1'b1};
                                    for (int i = 0; i < CAPACITY - 1; i++) begin
                                        r_ids[i]  <= r_ids[i+1];
                                        r_prio[i] <= r_prio[i+1];
                                    end
                                    r_cnt <= v_cnt;
                                    if (r_cur_v) begin
                                        if (r_cur == '0) r_cur_v <= 1'b0;
                                        else r_cur <= r_cur - IW'(1);
                                    end
                                end
                            end
                            F_FIND, F_REMID: begin
                                if (w_found) begin
                                    if (r_cmd.func == F_REMID) begin
                                        v_do_rm = 1'b1;
                                        v_rm    = w_fpos;
                                        v_cnt   = r_cnt - CW'(1);
                                    end
                                    v_res = '{element_out: r_cmd.element_id,
                                              valid_res: 1'b1, flushed: 1'b0,
                                              ok: 1'b1,
                                              position: POS_W'(w_fpos),
                                              occupancy: OCC_W'(v_cnt),
                                              last: 1'b1};
                                end
                            end
                            F_FIRST: begin
                                r_cur   <= '0;
                                r_cur_v <= (r_cnt != '0);
                                if (r_cnt != '0)
                                    v_res = '{element_out: r_ids[0],
                                              valid_res: 1'b1, flushed: 1'b0,
                                              ok: 1'b1, position: '0,
                                              occupancy: OCC_W'(r_cnt),
                                              last: 1'b1};
                            end
                            F_NEXT: begin
                                if (r_cur_v && (CW'(r_cur) + CW'(1) < r_cnt)) begin
                                    r_cur <= r_cur + IW'(1);
                                    v_res = '{element_out: r_ids[r_cur + IW'(1)],
                                              valid_res: 1'b1, flushed: 1'b0,
                                              ok: 1'b1,
                                              position: POS_W'(r_cur) + POS_W'(1),
                                              occupancy: OCC_W'(r_cnt),
                                              last: 1'b1};
                                end else begin
                                    r_cur_v <= 1'b0;
                                    r_cur   <= '0;
                                end
                            end
                            F_REMCUR: begin
                                if (r_cur_v && CW'(r_cur) < r_cnt) begin
                                    v_do_rm = 1'b1;
                                    v_rm    = CW'(r_cur);
                                    v_cnt   = r_cnt - CW'(1);
                                    v_res = '{element_out: r_ids[r_cur],
                                              valid_res: 1'b1, flushed: 1'b0,
                                              ok: 1'b1,
                                              position: POS_W'(r_cur),
                                              occupancy: OCC_W'(v_cnt),
                                              last: 1'b1};
                                end else begin
                                    r_cur_v <= 1'b0;
                                end
                            end
                            default: begin
                                // clear: flush already done
                                v_res = '{element_out: '0, valid_res: 1'b0,
                                          flushed: 1'b0, ok: 1'b1,
                                          position: '0, occupancy: '0,
                                          last: 1'b1};
                            end
                        endcase
                        // remove one entry and repair the cursor
                        if (v_do_rm) begin
                            for (int i = 0; i < CAPACITY - 1; i++) begin
                                if (CW'(i) >= v_rm) begin
                                    r_ids[i]  <= r_ids[i+1];
                                    r_prio[i] <= r_prio[i+1];
                                end
                            end
                            r_cnt <= v_cnt;
                            if (r_cur_v) begin
                                if (CW'(r_cur) == v_rm) begin
                                    if (v_rm != '0) r_cur <= r_cur - IW'(1);
                                    else if (v_cnt == '0) r_cur_v <= 1'b0;
                                end else if (CW'(r_cur) > v_rm) begin
                                    r_cur <= r_cur - IW'(1);
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // commit the result register once per cycle
            r_res   <= v_res;
            r_res_v <= v_res_v;
        end
    end

    assign m_res.valid       = r_res_v;
    assign m_res.element_out = r_res.element_out;
    assign m_res.valid_res   = r_res.valid_res;
    assign m_res.flushed     = r_res.flushed;
    assign m_res.ok          = r_res.ok;
    assign m_res.position    = r_res.position;
    assign m_res.occupancy   = r_res.occupancy;
    assign m_res.last        = r_res.last;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY)) else $error("count above capacity");
    a_cur_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_v |-> (CW'(r_cur) < r_cnt)) else $error("cursor out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_v && !m_res.ready) |=> $stable(r_res)) else $error("result changed");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> !(r_res_v && r_res.last) || $past(r_res_v && r_res.last))
        else $error("last during flush");
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import bpq_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 5000;

    // Queue contents, kept sorted the same way the block keeps them.
    class pq_scoreboard;
        logic [ID_W-1:0]   ids[CAP];
        logic [PRIO_W-1:0] prios[CAP];
        int unsigned       count;
        int unsigned       cur_idx;
        bit                cur_ok;
        t_res              pending[$];
        int unsigned       errors;

        function new();
            count = 0;
            cur_idx = 0;
            cur_ok = 0;
            errors = 0;
        endfunction

        function void push_res(logic [ID_W-1:0] e, bit v, bit f, bit k,
                               int unsigned p, int unsigned occ, bit lst);
            t_res r;
            r.element_out = e;
            r.valid_res = v;
            r.flushed = f;
            r.ok = k;
            r.position = p[POS_W-1:0];
            r.occupancy = occ[OCC_W-1:0];
            r.last = lst;
            pending.push_back(r);
        endfunction

        // Report every held entry as flushed, head first, and empty the queue.
        function void flush_entries(int unsigned occ);
            for (int i = 0; i < count; i++)
                push_res(ids[i], 1, 1, 0, i, occ, 0);
            count = 0;
            cur_ok = 0;
            cur_idx = 0;
        endfunction

        // Drop the entry at idx; a cursor on it falls back to the predecessor, or stays at the head.
        function void drop_at(int unsigned idx);
            for (int i = idx; i + 1 < count; i++) begin
                ids[i] = ids[i+1];
                prios[i] = prios[i+1];
            end
            count--;
            if (cur_ok) begin
                if (cur_idx == idx) begin
                    if (idx > 0) cur_idx = idx - 1;
                    else if (count > 0) cur_idx = 0;
                    else cur_ok = 0;
                end else if (cur_idx > idx) begin
                    cur_idx--;
                end
            end
        endfunction

        function int find_first(logic [ID_W-1:0] id);
            for (int i = 0; i < count; i++)
                if (ids[i] == id) return i;
            return -1;
        endfunction

        // Note an accepted command and predict its results.
        function void note_cmd(t_func fn, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
            int unsigned p;
            int fp;
            logic [ID_W-1:0] e;
            p = 0;
            case (fn)
                F_ENQ: begin
                    if (count >= CAP) flush_entries(1);
                    while (p < count && prios[p] >= pr) p++;
                    for (int i = count; i > p; i--) begin
                        ids[i] = ids[i-1];
                        prios[i] = prios[i-1];
                    end
                    ids[p] = id;
                    prios[p] = pr;
                    count++;
                    if (cur_ok && cur_idx >= p) cur_idx++;
                    push_res(id, 1, 0, 1, p, count, 1);
                end
                F_DEQ: begin
                    if (count == 0) begin
                        push_res(0, 0, 0, 0, 0, 0, 1);
                    end else begin
                        e = ids[0];
                        for (int i = 0; i + 1 < count; i++) begin
                            ids[i] = ids[i+1];
                            prios[i] = prios[i+1];
                        end
                        count--;
                        if (cur_ok) begin
                            if (cur_idx == 0) cur_ok = 0;
                            else cur_idx--;
                        end
                        push_res(e, 1, 0, 1, 0, count, 1);
                    end
                end
                F_FIND, F_REMID: begin
                    fp = find_first(id);
                    if (fp < 0) begin
                        push_res(0, 0, 0, 0, 0, count, 1);
                    end else begin
                        if (fn == F_REMID) drop_at(fp);
                        push_res(id, 1, 0, 1, fp, count, 1);
                    end
                end
                F_FIRST: begin
                    cur_idx = 0;
                    cur_ok = count > 0;
                    if (cur_ok) push_res(ids[0], 1, 0, 1, 0, count, 1);
                    else push_res(0, 0, 0, 0, 0, count, 1);
                end
                F_NEXT: begin
                    if (cur_ok) begin
                        cur_idx++;
                        if (cur_idx >= count) cur_ok = 0;
                    end
                    if (!cur_ok) begin
                        cur_idx = 0;
                        push_res(0, 0, 0, 0, 0, count, 1);
                    end else begin
                        push_res(ids[cur_idx], 1, 0, 1, cur_idx, count, 1);
                    end
                end
                F_REMCUR: begin
                    if (!cur_ok || cur_idx >= count) begin
                        cur_ok = 0;
                        push_res(0, 0, 0, 0, 0, count, 1);
                    end else begin
                        p = cur_idx;
                        e = ids[p];
                        drop_at(p);
                        push_res(e, 1, 0, 1, p, count, 1);
                    end
                end
                default: begin
                    flush_entries(0);
                    push_res(0, 0, 0, 1, 0, 0, 1);
                end
            endcase
        endfunction

        function void report_mismatch(string what, int unsigned got, int unsigned want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endfunction

        // Compare one transferred result with the oldest prediction.
        function void check_res(t_res got);
            t_res w;
            if (pending.size() == 0) begin
                $display("mismatch at %0t: result with nothing pending", $time);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.element_out !== w.element_out)
                report_mismatch("element_out", got.element_out, w.element_out);
            if (got.valid_res !== w.valid_res)
                report_mismatch("valid_res", got.valid_res, w.valid_res);
            if (got.flushed !== w.flushed) report_mismatch("flushed", got.flushed, w.flushed);
            if (got.ok !== w.ok) report_mismatch("ok", got.ok, w.ok);
            if (got.position !== w.position)
                report_mismatch("position", got.position, w.position);
            if (got.occupancy !== w.occupancy)
                report_mismatch("occupancy", got.occupancy, w.occupancy);
            if (got.last !== w.last) report_mismatch("last", got.last, w.last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bpq_cmd_if cmd_ch ();
    bpq_res_if res_ch ();

    pq_scoreboard sb;
    bit stall_free;
    int unsigned quiet_cycles;

    bounded_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_cmd   (cmd_ch.sink),
        .m_res   (res_ch.source)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // Receiver: stall at random, check each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_res r;
                r.element_out = res_ch.element_out;
                r.valid_res = res_ch.valid_res;
                r.flushed = res_ch.flushed;
                r.ok = res_ch.ok;
                r.position = res_ch.position;
                r.occupancy = res_ch.occupancy;
                r.last = res_ch.last;
                sb.check_res(r);
            end
            res_ch.ready <= stall_free || ($urandom_range(99) >= 13);
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one command and hold it until transferred.
    task automatic send_cmd(t_func fn, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
        while (!stall_free && $urandom_range(99) < 13) begin
            cmd_ch.valid <= 0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1;
        cmd_ch.func <= fn;
        cmd_ch.element_id <= id;
        cmd_ch.priority_req <= pr;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_cmd(fn, id, pr);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Mostly id values from a small pool, so find and remove hit often.
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(9))
            0: return ID_W'($urandom_range(16'hFFFF));
            1: return 16'hFFFF;
            default: return ID_W'($urandom_range(20));
        endcase
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(5))
            0: return 8'hFF;
            1: return 8'h00;
            2: return PRIO_W'($urandom_range(255));
            default: return PRIO_W'($urandom_range(3));
        endcase
    endfunction

    initial begin
        t_func fn;
        sb = new();
        stall_free = 0;
        quiet_cycles = 0;
        i_rst_n = 0;
        cmd_ch.valid = 0;
        cmd_ch.func = F_ENQ;
        cmd_ch.element_id = 0;
        cmd_ch.priority_req = 0;
        res_ch.ready = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty-queue cases, extremes, ties, cursor repairs, flushes.
        send_cmd(F_DEQ, 0, 0);
        send_cmd(F_FIRST, 0, 0);
        send_cmd(F_NEXT, 0, 0);
        send_cmd(F_REMCUR, 0, 0);
        send_cmd(F_FIND, 16'hFFFF, 0);
        send_cmd(F_ENQ, 16'hFFFF, 8'hFF);
        send_cmd(F_ENQ, 16'h0000, 8'h00);
        send_cmd(F_ENQ, 16'h1234, 8'hFF);
        send_cmd(F_ENQ, 16'h1234, 8'h80);
        send_cmd(F_FIRST, 0, 0);
        send_cmd(F_DEQ, 0, 0);
        send_cmd(F_NEXT, 0, 0);
        send_cmd(F_FIRST, 0, 0);
        send_cmd(F_NEXT, 0, 0);
        send_cmd(F_REMCUR, 0, 0);
        send_cmd(F_FIND, 16'h0000, 0);
        send_cmd(F_REMID, 16'h1234, 0);
        send_cmd(F_REMID, 16'hABCD, 0);
        send_cmd(F_CLEAR, 0, 0);
        for (int i = 0; i < CAP + 1; i++)
            send_cmd(F_ENQ, ID_W'($urandom_range(16'hFFFF)), PRIO_W'($urandom_range(255)));
        send_cmd(F_CLEAR, 0, 0);

        // Pause until every prediction has been matched.
        wait_drained();

        // Random: fill-heavy bursts, plus a stretch with no stalls.
        for (int n = 0; n < 430; n++) begin
            stall_free = (n >= 150 && n < 230);
            if (n == 300) wait_drained();
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: fn = F_ENQ;
                7, 8: fn = F_DEQ;
                9, 10: fn = F_FIND;
                11, 12: fn = F_REMID;
                13: fn = F_FIRST;
                14, 15, 16: fn = F_NEXT;
                17, 18: fn = F_REMCUR;
                default: fn = ($urandom_range(3) == 0) ? F_CLEAR : F_ENQ;
            endcase
            send_cmd(fn, pick_id(), pick_prio());
        end
        stall_free = 0;
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
